// ===== design/cwes_pkg.sv =====
// shared types, codes and helpers for the clock with encoder setting
// no dependencies; imported by clock_with_encoder_setting
package cwes_pkg;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_W-1:0] TICKS_PER_SECOND_RST   = 16'd40000;
	localparam logic [CFG_W-1:0] BLANK_AFTER_TICKS_RST  = 16'd20000;
	localparam logic [CFG_W-1:0] TIME_BLINK_PERIOD_RST  = 16'd60000;
	localparam logic [CFG_W-1:0] LEVEL_BLINK_PERIOD_RST = 16'd40000;

	localparam logic [5:0] SECONDS_MAX = 6'd59;
	localparam logic [5:0] MINUTES_MAX = 6'd59;
	localparam logic [4:0] HOURS_MAX   = 5'd23;
	localparam logic [2:0] LEVEL_RST   = 3'd5;
	localparam logic [2:0] LEVEL_MAX   = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICKS_PER_SECOND   = 2'd0,
		CFG_BLANK_AFTER_TICKS  = 2'd1,
		CFG_TIME_BLINK_PERIOD  = 2'd2,
		CFG_LEVEL_BLINK_PERIOD = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_DOWN  = 2'd1,
		EV_UP    = 2'd2,
		EV_PRESS = 2'd3
	} enc_event_t;

	typedef enum logic [2:0] {
		MODE_RUN       = 3'd0,
		MODE_SET_SEC   = 3'd1,
		MODE_SET_MIN   = 3'd2,
		MODE_SET_HR    = 3'd3,
		MODE_SET_LEVEL = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		BLANK_NONE    = 3'd0,
		BLANK_SECONDS = 3'd1,
		BLANK_MINUTES = 3'd2,
		BLANK_HOURS   = 3'd3,
		BLANK_ALL     = 3'd4
	} blank_t;

	typedef struct packed {
		logic [1:0] encoder_event;
		logic       long_press;
	} req_t;

	typedef struct packed {
		logic [4:0] hours_now;
		logic [5:0] minutes_now;
		logic [5:0] seconds_now;
		logic [2:0] mode_now;
		logic [2:0] blanked_field;
		logic [2:0] brightness_now;
		logic       save_time;
		logic       save_brightness;
	} rsp_t;

	// one step of a time field with wraparound at both ends
	function automatic logic [5:0] step_field(logic [5:0] v, logic [5:0] maxv, logic up);
		logic [5:0] r;
		if (up) begin
			r = (v >= maxv) ? 6'd0 : v + 6'd1;
		end else begin
			r = (v == 6'd0 || v > maxv) ? maxv : v - 6'd1;
		end
		return r;
	endfunction

endpackage

// ===== design/clock_with_encoder_setting.sv =====
// 24-hour clock with encoder set modes: an accepted request sits in the input register, and
// its result is loaded from there into the result register, where it is valid; one request
// per cycle while out_stall does not hold the result register, with the time and blink
// counters updated between the two registers. arst_n clears time, mode and counters,
// sets brightness to 5 and the config registers to their defaults
// depends on cwes_pkg
module clock_with_encoder_setting
	import cwes_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  req_t                 in_data,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output rsp_t                 out_data,
	// config write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// config registers
	logic [CFG_W-1:0] ticks_per_second_q;
	logic [CFG_W-1:0] blank_after_ticks_q;
	logic [CFG_W-1:0] time_blink_period_q;
	logic [CFG_W-1:0] level_blink_period_q;

	// input stage
	logic valid_s1;
	req_t req_s1;

	// clock state
	logic [15:0] tick_count_q, tick_count_n;
	logic [15:0] blink_count_q, blink_count_n;
	mode_t       mode_q, mode_n;
	logic [4:0]  hours_q, hours_n;
	logic [5:0]  minutes_q, minutes_n;
	logic [5:0]  seconds_q, seconds_n;
	logic [2:0]  level_q, level_n;
	logic        blank_q, blank_n;

	// result stage
	logic out_valid_q;
	rsp_t out_data_q;
	rsp_t rsp_n;

	logic out_free;
	logic advance;

	// result register can take a new request when empty or being drained
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	// input register holds a request only while it cannot move on
	assign in_stall  = valid_s1 && !out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// config writes, only while idle; the user is bound to this, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_second_q   <= TICKS_PER_SECOND_RST;
			blank_after_ticks_q  <= BLANK_AFTER_TICKS_RST;
			time_blink_period_q  <= TIME_BLINK_PERIOD_RST;
			level_blink_period_q <= LEVEL_BLINK_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TICKS_PER_SECOND:   ticks_per_second_q   <= cfg_data;
				CFG_BLANK_AFTER_TICKS:  blank_after_ticks_q  <= cfg_data;
				CFG_TIME_BLINK_PERIOD:  time_blink_period_q  <= cfg_data;
				CFG_LEVEL_BLINK_PERIOD: level_blink_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	// next state and result for the request in the input register
	always_comb begin
		logic [15:0] period;
		logic [15:0] blink_base;
		logic [15:0] tick_inc;
		logic [5:0]  hr_wide;
		logic        save_t;
		logic        save_b;
		logic        up;
		logic        lp;
		enc_event_t  ev;
		blank_t      blanked;

		tick_count_n  = tick_count_q;
		blink_count_n = blink_count_q;
		mode_n        = mode_q;
		hours_n       = hours_q;
		minutes_n     = minutes_q;
		seconds_n     = seconds_q;
		level_n       = level_q;
		blank_n       = blank_q;
		save_t        = 1'b0;
		save_b        = 1'b0;
		ev            = enc_event_t'(req_s1.encoder_event);
		lp            = req_s1.long_press;
		up            = (ev == EV_UP);
		tick_inc      = tick_count_q + 16'd1;
		hr_wide       = step_field({1'b0, hours_q}, {1'b0, HOURS_MAX}, up);

		// blink counter, shared by all set modes
		period     = (mode_q == MODE_SET_LEVEL) ? level_blink_period_q : time_blink_period_q;
		blink_base = blink_count_q;
		if (blink_count_q == 16'd1) begin
			blank_n = 1'b0;
		end else if (blink_count_q == blank_after_ticks_q) begin
			blank_n = 1'b1;
		end else if (blink_count_q == period) begin
			blink_base = 16'd0;
		end

		unique case (mode_q)
			MODE_SET_SEC, MODE_SET_MIN, MODE_SET_HR: begin
				blink_count_n = blink_base + 16'd1;
				if (lp) begin
					mode_n  = MODE_RUN;
					blank_n = 1'b0;
				end else if (ev == EV_UP || ev == EV_DOWN) begin
					if (mode_q == MODE_SET_SEC) begin
						seconds_n = step_field(seconds_q, SECONDS_MAX, up);
					end else if (mode_q == MODE_SET_MIN) begin
						minutes_n = step_field(minutes_q, MINUTES_MAX, up);
					end else begin
						hours_n = hr_wide[4:0];
					end
					blank_n = 1'b0;
				end else if (ev == EV_PRESS) begin
					// seconds -> minutes -> hours -> brightness
					mode_n  = mode_t'(mode_q + 3'd1);
					blank_n = 1'b0;
				end
			end
			MODE_SET_LEVEL: begin
				blink_count_n = blink_base + 16'd1;
				if (ev == EV_DOWN) begin
					// turn down raises the level, 7 wraps to 0
					level_n = level_q + 3'd1;
					blank_n = 1'b0;
				end else if (ev == EV_UP) begin
					// turn up lowers it, never landing on 0
					level_n = (level_q <= 3'd1) ? LEVEL_MAX : level_q - 3'd1;
					blank_n = 1'b0;
				end else if (ev == EV_PRESS) begin
					save_b  = 1'b1;
					mode_n  = MODE_RUN;
					blank_n = 1'b0;
				end
			end
			default: begin
				// run mode; blink counter untouched, flag kept unless a press clears it
				blank_n      = blank_q;
				tick_count_n = tick_inc;
				if (tick_inc >= ticks_per_second_q) begin
					tick_count_n = 16'd0;
					save_t       = 1'b1;
					if (seconds_q >= SECONDS_MAX) begin
						seconds_n = 6'd0;
						if (minutes_q >= MINUTES_MAX) begin
							minutes_n = 6'd0;
							hours_n   = (hours_q >= HOURS_MAX) ? 5'd0 : hours_q + 5'd1;
						end else begin
							minutes_n = minutes_q + 6'd1;
						end
					end else begin
						seconds_n = seconds_q + 6'd1;
					end
				end
				// long press wins over short press
				if (lp) begin
					mode_n  = MODE_SET_LEVEL;
					blank_n = 1'b0;
				end else if (ev == EV_PRESS) begin
					mode_n  = MODE_SET_SEC;
					blank_n = 1'b0;
				end else begin
					mode_n = MODE_RUN;
				end
			end
		endcase

		// field being edited goes dark while the flag is up; in brightness mode all fields do
		blanked = BLANK_NONE;
		if (blank_n && mode_n != MODE_RUN) begin
			blanked = blank_t'(mode_n);
		end

		rsp_n.hours_now       = hours_n;
		rsp_n.minutes_now     = minutes_n;
		rsp_n.seconds_now     = seconds_n;
		rsp_n.mode_now        = mode_n;
		rsp_n.blanked_field   = blanked;
		rsp_n.brightness_now  = level_n;
		rsp_n.save_time       = save_t;
		rsp_n.save_brightness = save_b;
	end

	// clock state, updated once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q  <= '0;
			blink_count_q <= '0;
			mode_q        <= MODE_RUN;
			hours_q       <= '0;
			minutes_q     <= '0;
			seconds_q     <= '0;
			level_q       <= LEVEL_RST;
			blank_q       <= 1'b0;
		end else if (advance) begin
			tick_count_q  <= tick_count_n;
			blink_count_q <= blink_count_n;
			mode_q        <= mode_n;
			hours_q       <= hours_n;
			minutes_q     <= minutes_n;
			seconds_q     <= seconds_n;
			level_q       <= level_n;
			blank_q       <= blank_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= rsp_n;
		end
	end

endmodule
